// ===== rtl/bmc_pkg.sv =====
// Shared types and constants for the binary morphological closing block.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bmc_pkg;

	// Frame limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_SIZE   = 3;

	// Row store: ring of binarized rows, one bit per row slot in each column word
	localparam int ROW_SLOTS = 8;
	localparam int SLOT_W    = $clog2(ROW_SLOTS);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);

	// Size register field width
	localparam int SIZE_W = 11;

	// Pending input count: up to three rows plus two pixels
	localparam int AHEAD_W = $clog2(3 * MAX_WIDTH + 3);

	// Window column: rows y-2 .. y+3, center row at index CTR
	localparam int COL_ROWS = 6;
	localparam int CTR      = 2;

	// Token queue between front and back
	localparam int TQ_DEPTH = 4;
	localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
	localparam int TQ_CNT_W = $clog2(TQ_DEPTH + 1);

	// Pixels and commands
	localparam int PIX_W = 8;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
	localparam logic CMD_PIXEL = 1'b0;

	// Configuration port
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_OBJECT_IS_BLACK = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd2;
	localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd91;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd108;

	// Effective configuration (sizes already clamped)
	typedef struct packed {
		logic               black;
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
		logic [AHEAD_W-1:0] thresh;
	} cfg_t;

	typedef logic [COL_ROWS-1:0] tcol_t;

	// One output job: center and right window columns plus row validity
	typedef struct packed {
		tcol_t center;
		tcol_t right;
		tcol_t row_ok;
		logic  first_col;
		logic  frame_end;
	} tok_t;

	typedef struct packed {
		logic                empty;
		logic [TQ_CNT_W-1:0] count;
	} tq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bmc_front.sv =====
// Front end: accepts pixels and flush beats, binarizes, keeps the row store and
// frame counters, and issues window columns for each due output. Uses bmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmc_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bmc_pkg::cfg_t             cfg,
	input  wire logic                      clear,
	input  wire logic                      push,
	input  wire logic                      command,
	input  wire logic [bmc_pkg::PIX_W-1:0] pixel_in,
	output logic                           full,
	input  wire bmc_pkg::tq_stat_t         tq_stat,
	output logic                           tok_push,
	output bmc_pkg::tok_t                  tok
);

	// Pick rows y-2 .. y+3 out of a column word, y given by its slot
	function automatic bmc_pkg::tcol_t pick_rows(
		input logic [bmc_pkg::ROW_SLOTS-1:0] word,
		input logic [bmc_pkg::SLOT_W-1:0]    base
	);
		bmc_pkg::tcol_t col;
		for (int k = 0; k < bmc_pkg::COL_ROWS; k++) begin
			col[k] = word[bmc_pkg::SLOT_W'(int'(base) + k + bmc_pkg::ROW_SLOTS - bmc_pkg::CTR)];
		end
		return col;
	endfunction

	// Row store
	logic [bmc_pkg::ROW_SLOTS-1:0] row_mem [bmc_pkg::MAX_WIDTH];

	// Counters
	logic [bmc_pkg::COL_W-1:0]   in_col_q;
	logic [bmc_pkg::ROW_W-1:0]   in_row_q;
	logic                        done_q;
	logic [bmc_pkg::COL_W-1:0]   out_col_q;
	logic [bmc_pkg::ROW_W-1:0]   out_row_q;
	logic [bmc_pkg::AHEAD_W-1:0] ahead_q;

	// Stage 1
	logic                          emit_s1;
	logic [bmc_pkg::ROW_SLOTS-1:0] rd_a_s1;
	logic [bmc_pkg::ROW_SLOTS-1:0] rd_b_s1;
	logic                          hit_a_s1;
	logic                          hit_b_s1;
	logic [bmc_pkg::SLOT_W-1:0]    wslot_s1;
	logic                          wbit_s1;
	logic [bmc_pkg::SLOT_W-1:0]    yslot_s1;
	bmc_pkg::tcol_t                ok_s1;
	logic                          first_s1;
	logic                          fend_s1;

	logic                          acc;
	logic                          is_pix;
	logic                          bin;
	logic [bmc_pkg::SIZE_W-1:0]    w_last;
	logic [bmc_pkg::SIZE_W-1:0]    h_last;
	logic                          last_col_in;
	logic                          last_row_in;
	logic                          done_n;
	logic [bmc_pkg::AHEAD_W-1:0]   ahead_a;
	logic                          emit;
	logic                          last_col_out;
	logic                          last_row_out;
	logic                          frame_done;
	logic [bmc_pkg::COL_W-1:0]     addr_a;
	logic [bmc_pkg::COL_W-1:0]     addr_b;
	logic [bmc_pkg::SIZE_W-1:0]    rows_left;
	bmc_pkg::tcol_t                row_ok;
	logic [bmc_pkg::ROW_SLOTS-1:0] col_a;
	logic [bmc_pkg::ROW_SLOTS-1:0] col_b;

	// Back pressure: room for the beat in stage 1 and one more
	assign full = (tq_stat.count + bmc_pkg::TQ_CNT_W'(emit_s1)) >=
		bmc_pkg::TQ_CNT_W'(bmc_pkg::TQ_DEPTH);

	// Classify the beat and decide whether an output is due
	always_comb begin
		acc          = push && !full;
		is_pix       = acc && (command == bmc_pkg::CMD_PIXEL) && !done_q;
		bin          = cfg.black ? (pixel_in == '0) : (pixel_in == bmc_pkg::PIX_MAX);
		w_last       = cfg.width - bmc_pkg::SIZE_W'(1);
		h_last       = cfg.height - bmc_pkg::SIZE_W'(1);
		last_col_in  = bmc_pkg::SIZE_W'(in_col_q) == w_last;
		last_row_in  = bmc_pkg::SIZE_W'(in_row_q) == h_last;
		done_n       = done_q || (is_pix && last_col_in && last_row_in);
		ahead_a      = ahead_q + bmc_pkg::AHEAD_W'(is_pix);
		emit         = acc && (done_n ? (ahead_a != '0) : (ahead_a >= cfg.thresh));
		last_col_out = bmc_pkg::SIZE_W'(out_col_q) == w_last;
		last_row_out = bmc_pkg::SIZE_W'(out_row_q) == h_last;
		frame_done   = emit && last_col_out && last_row_out;
	end

	// Read addresses: this column and the one to its right, clamped at the edge
	always_comb begin
		addr_a = out_col_q;
		addr_b = last_col_out ? out_col_q : out_col_q + bmc_pkg::COL_W'(1);
	end

	// Which rows of the window lie inside the frame
	always_comb begin
		rows_left = h_last - bmc_pkg::SIZE_W'(out_row_q);
		row_ok[0] = out_row_q >= bmc_pkg::ROW_W'(2);
		row_ok[1] = out_row_q >= bmc_pkg::ROW_W'(1);
		row_ok[2] = 1'b1;
		row_ok[3] = rows_left >= bmc_pkg::SIZE_W'(1);
		row_ok[4] = rows_left >= bmc_pkg::SIZE_W'(2);
		row_ok[5] = rows_left >= bmc_pkg::SIZE_W'(3);
	end

	// Frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			done_q    <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
			ahead_q   <= '0;
		end else if (clear || frame_done) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			done_q    <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
			ahead_q   <= '0;
		end else begin
			if (is_pix) begin
				if (last_col_in) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + bmc_pkg::ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + bmc_pkg::COL_W'(1);
				end
			end
			done_q  <= done_n;
			ahead_q <= emit ? ahead_a - bmc_pkg::AHEAD_W'(1) : ahead_a;
			if (emit) begin
				if (last_col_out) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + bmc_pkg::ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + bmc_pkg::COL_W'(1);
				end
			end
		end
	end

	// Row store: bit write of the new pixel, two registered column reads
	always_ff @(posedge clk) begin
		if (is_pix) begin
			row_mem[in_col_q][in_row_q[bmc_pkg::SLOT_W-1:0]] <= bin;
		end
		if (emit) begin
			rd_a_s1 <= row_mem[addr_a];
			rd_b_s1 <= row_mem[addr_b];
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
		end else begin
			emit_s1 <= emit;
		end
	end

	// Stage 1 payload, including the same-cycle write for bypass
	always_ff @(posedge clk) begin
		if (emit) begin
			hit_a_s1 <= is_pix && (in_col_q == addr_a);
			hit_b_s1 <= is_pix && (in_col_q == addr_b);
			wslot_s1 <= in_row_q[bmc_pkg::SLOT_W-1:0];
			wbit_s1  <= bin;
			yslot_s1 <= out_row_q[bmc_pkg::SLOT_W-1:0];
			ok_s1    <= row_ok;
			first_s1 <= out_col_q == '0;
			fend_s1  <= last_col_out && last_row_out;
		end
	end

	// Merge the bypassed bit and line the rows up around the center row
	always_comb begin
		col_a = rd_a_s1;
		col_b = rd_b_s1;
		if (hit_a_s1) begin
			col_a[wslot_s1] = wbit_s1;
		end
		if (hit_b_s1) begin
			col_b[wslot_s1] = wbit_s1;
		end
		tok_push      = emit_s1;
		tok.center    = pick_rows(col_a, yslot_s1);
		tok.right     = pick_rows(col_b, yslot_s1);
		tok.row_ok    = ok_s1;
		tok.first_col = first_s1;
		tok.frame_end = fend_s1;
	end

endmodule

`default_nettype wire

// ===== rtl/bmc_fifo.sv =====
// Short queue of output jobs between the front end and the back end.
// Uses bmc_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module bmc_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bmc_pkg::tok_t     din,
	input  wire logic              pop,
	output bmc_pkg::tok_t          dout,
	output bmc_pkg::tq_stat_t      stat
);

	bmc_pkg::tok_t                mem_q [bmc_pkg::TQ_DEPTH];
	logic [bmc_pkg::TQ_PTR_W-1:0] wr_ptr_q;
	logic [bmc_pkg::TQ_PTR_W-1:0] rd_ptr_q;
	logic [bmc_pkg::TQ_CNT_W-1:0] count_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bmc_pkg::TQ_PTR_W'(bmc_pkg::TQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + bmc_pkg::TQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bmc_pkg::TQ_PTR_W'(bmc_pkg::TQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + bmc_pkg::TQ_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + bmc_pkg::TQ_CNT_W'(1);
				2'b01: count_q <= count_q - bmc_pkg::TQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	assign dout       = mem_q[rd_ptr_q];
	assign stat.empty = count_q == '0;
	assign stat.count = count_q;

endmodule

`default_nettype wire

// ===== rtl/bmc_back.sv =====
// Back end: builds the 3-column window from queued jobs, applies dilation and
// erosion, and holds the result beat for the consumer. Uses bmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      black,
	input  wire bmc_pkg::tok_t             head,
	input  wire logic                      head_valid,
	output logic                           head_pop,
	input  wire logic                      pop,
	output logic                           empty,
	output logic [bmc_pkg::PIX_W-1:0]      pixel_out,
	output logic                           frame_end
);

	// Closing at the center pixel; rows outside the frame drop out of the AND
	function automatic logic close_bit(
		input bmc_pkg::tcol_t l,
		input bmc_pkg::tcol_t c,
		input bmc_pkg::tcol_t r,
		input bmc_pkg::tcol_t ok,
		input logic           blk
	);
		logic e;
		logic up;
		logic dn;
		e = 1'b1;
		if (blk) begin
			// cross dilation, vertical 3-point erosion
			for (int k = bmc_pkg::CTR - 1; k <= bmc_pkg::CTR + 1; k++) begin
				up = ok[k-1] ? c[k-1] : c[k];
				dn = ok[k+1] ? c[k+1] : c[k];
				if (ok[k]) begin
					e = e & (c[k] | up | dn | l[k] | r[k]);
				end
			end
		end else begin
			// pixel-and-below dilation; 3x3 square on rows y-1..y+1,
			// center column only on rows y-2 and y+2
			for (int k = bmc_pkg::CTR - 2; k <= bmc_pkg::CTR + 2; k++) begin
				if (ok[k]) begin
					e = e & (c[k] | (ok[k+1] ? c[k+1] : c[k]));
					if (k >= bmc_pkg::CTR - 1 && k <= bmc_pkg::CTR + 1) begin
						e = e & (l[k] | (ok[k+1] ? l[k+1] : l[k]))
							& (r[k] | (ok[k+1] ? r[k+1] : r[k]));
					end
				end
			end
		end
		return e;
	endfunction

	logic                     out_valid_q;
	bmc_pkg::tcol_t           prev_center_q;
	logic [bmc_pkg::PIX_W-1:0] pix_q;
	logic                     fend_q;

	logic                     take;
	bmc_pkg::tcol_t           left;
	logic                     obj;

	// Take a job whenever the result register is free or being emptied
	always_comb begin
		take     = head_valid && (!out_valid_q || pop);
		head_pop = take;
		left     = head.first_col ? head.center : prev_center_q;
		obj      = close_bit(left, head.center, head.right, head.row_ok, black);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result beat and left-column history
	always_ff @(posedge clk) begin
		if (take) begin
			prev_center_q <= head.center;
			pix_q         <= (obj ^ black) ? bmc_pkg::PIX_MAX : '0;
			fend_q        <= head.frame_end;
		end
	end

	assign empty     = !out_valid_q;
	assign pixel_out = pix_q;
	assign frame_end = fend_q;

endmodule

`default_nettype wire

// ===== rtl/binary_morphological_closing.sv =====
// Top level of the binary morphological closing block: configuration
// registers and the front end / job queue / back end. Uses bmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Closes a raster stream of 8-bit pixels (dilation, then erosion) one pixel per
// clock. W and H are the size registers clamped to 3..1024. Results trail the
// input by 3*W+1 pixels: the first result of a frame comes out with input pixel
// 3*W+2, and after the last pixel of a frame the remaining results are released
// one per flush beat (command = 1); a pixel sent while results still lag is
// ignored and acts as a flush. A released result passes stage 1, the job queue
// and the result register. The block takes a beat each clock as long as results
// are popped; a four-entry job queue and the result register absorb short pop
// stalls before full rises. The 8-row x 1024-column row store needs no clearing
// after reset, since every pixel a frame reads was written earlier in that
// frame. A mapped register write starts a new frame; write only while idle.
module binary_morphological_closing (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic                        command,
	input  wire logic [bmc_pkg::PIX_W-1:0]   pixel_in,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [bmc_pkg::PIX_W-1:0]        pixel_out,
	output logic                             frame_end,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bmc_pkg::APB_AW-1:0]  paddr,
	input  wire logic [bmc_pkg::APB_DW-1:0]  pwdata,
	output logic [bmc_pkg::APB_DW-1:0]       prdata,
	output logic                             pready
);

	logic                           black_q;
	logic [bmc_pkg::SIZE_W-1:0]     width_q;
	logic [bmc_pkg::SIZE_W-1:0]     height_q;

	logic                           cfg_wr;
	logic [bmc_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                           clear;
	bmc_pkg::cfg_t                  cfg;
	logic [bmc_pkg::AHEAD_W-1:0]    w_ext;

	logic                           tok_push;
	bmc_pkg::tok_t                  tok_in;
	bmc_pkg::tok_t                  tok_head;
	logic                           tok_pop;
	bmc_pkg::tq_stat_t              tq_stat;

	// Register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[bmc_pkg::APB_AW-1:2];

	always_comb begin
		unique case (reg_idx)
			bmc_pkg::REG_OBJECT_IS_BLACK: prdata = bmc_pkg::APB_DW'(black_q);
			bmc_pkg::REG_IMAGE_WIDTH:     prdata = bmc_pkg::APB_DW'(width_q);
			bmc_pkg::REG_IMAGE_HEIGHT:    prdata = bmc_pkg::APB_DW'(height_q);
			default:                      prdata = '0;
		endcase
	end

	// Writes to a listed register also restart the frame
	always_comb begin
		unique case (reg_idx)
			bmc_pkg::REG_OBJECT_IS_BLACK,
			bmc_pkg::REG_IMAGE_WIDTH,
			bmc_pkg::REG_IMAGE_HEIGHT: clear = cfg_wr;
			default:                   clear = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q  <= 1'b0;
			width_q  <= bmc_pkg::WIDTH_RST;
			height_q <= bmc_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bmc_pkg::REG_OBJECT_IS_BLACK: black_q  <= pwdata[0];
				bmc_pkg::REG_IMAGE_WIDTH:     width_q  <= pwdata[bmc_pkg::SIZE_W-1:0];
				bmc_pkg::REG_IMAGE_HEIGHT:    height_q <= pwdata[bmc_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped sizes and the release threshold 3*W+2
	always_comb begin
		cfg.black = black_q;
		priority if (width_q < bmc_pkg::SIZE_W'(bmc_pkg::MIN_SIZE)) begin
			cfg.width = bmc_pkg::SIZE_W'(bmc_pkg::MIN_SIZE);
		end else if (width_q > bmc_pkg::SIZE_W'(bmc_pkg::MAX_WIDTH)) begin
			cfg.width = bmc_pkg::SIZE_W'(bmc_pkg::MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		priority if (height_q < bmc_pkg::SIZE_W'(bmc_pkg::MIN_SIZE)) begin
			cfg.height = bmc_pkg::SIZE_W'(bmc_pkg::MIN_SIZE);
		end else if (height_q > bmc_pkg::SIZE_W'(bmc_pkg::MAX_HEIGHT)) begin
			cfg.height = bmc_pkg::SIZE_W'(bmc_pkg::MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
		w_ext      = bmc_pkg::AHEAD_W'(cfg.width);
		cfg.thresh = (w_ext << 1) + w_ext + bmc_pkg::AHEAD_W'(2);
	end

	bmc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.clear    (clear),
		.push     (push),
		.command  (command),
		.pixel_in (pixel_in),
		.full     (full),
		.tq_stat  (tq_stat),
		.tok_push (tok_push),
		.tok      (tok_in)
	);

	bmc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_push),
		.din    (tok_in),
		.pop    (tok_pop),
		.dout   (tok_head),
		.stat   (tq_stat)
	);

	bmc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.black      (cfg.black),
		.head       (tok_head),
		.head_valid (!tq_stat.empty),
		.head_pop   (tok_pop),
		.pop        (pop),
		.empty      (empty),
		.pixel_out  (pixel_out),
		.frame_end  (frame_end)
	);

	// The front end's credit check keeps the job queue from overflowing
	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		tok_push |-> (tq_stat.count != bmc_pkg::TQ_CNT_W'(bmc_pkg::TQ_DEPTH)))
		else $error("job queue written while full");

	// The back end only takes jobs that are there
	a_no_queue_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		tok_pop |-> !tq_stat.empty)
		else $error("job queue read while empty");

	// A result beat is always a clean binary pixel
	a_binary_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pixel_out == '0 || pixel_out == bmc_pkg::PIX_MAX))
		else $error("result pixel neither 0 nor 255");

endmodule

`default_nettype wire

// ===== bench/closing_checker.sv =====
// Checker for the binary morphological closing block: predicts every closed pixel
// from the accepted beats and register writes, and compares the popped results.
// Depends on bmc_pkg for sizes, register indexes and the pixel command code.
`timescale 1ns / 1ps

module closing_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	input  wire logic                               full,
	input  wire logic                               command,
	input  wire logic [bmc_pkg::PIX_W-1:0]          pixel_in,
	input  wire logic                               empty,
	input  wire logic                               pop,
	input  wire logic [bmc_pkg::PIX_W-1:0]          pixel_out,
	input  wire logic                               frame_end,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic                               pready,
	input  wire logic [bmc_pkg::APB_AW-1:0]         paddr,
	input  wire logic [bmc_pkg::APB_DW-1:0]         pwdata,
	output int                                      mismatches,
	output int                                      pending,
	output int                                      compared
);
	import bmc_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
	} closed_px_t;

	// Predicted results still waiting to be popped, oldest first
	closed_px_t closed_q[$];
	closed_px_t want;

	// Own copy of the binarized row ring, registers and raster counters
	bit                row_ring [ROW_SLOTS][MAX_WIDTH];
	logic              mode_black;
	logic [SIZE_W-1:0] width_val;
	logic [SIZE_W-1:0] height_val;
	int                in_col, in_row, out_col, out_row;
	int                w_eff, h_eff;

	function automatic int clip(input int v, input int lo, input int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// Binarized pixel with edge replication
	function automatic bit obj_at(input int r, input int c);
		return row_ring[clip(r, 0, h_eff - 1) % ROW_SLOTS][clip(c, 0, w_eff - 1)];
	endfunction

	// Dilation: pixel and the one below in white mode, 5-point cross in black mode
	function automatic bit grown_at(input int r, input int c);
		int rr, cc;
		rr = clip(r, 0, h_eff - 1);
		cc = clip(c, 0, w_eff - 1);
		if (!mode_black)
			return obj_at(rr, cc) | obj_at(rr + 1, cc);
		return obj_at(rr, cc) | obj_at(rr + 1, cc) | obj_at(rr - 1, cc)
			| obj_at(rr, cc + 1) | obj_at(rr, cc - 1);
	endfunction

	// Erosion: 3x3 square plus two rows away in white mode, vertical line in black
	function automatic bit closed_at(input int y, input int x);
		bit e;
		int dy, dx;
		e = 1'b1;
		if (mode_black) begin
			for (dy = -1; dy <= 1; dy++)
				e &= grown_at(y + dy, x);
			return e;
		end
		for (dy = -1; dy <= 1; dy++)
			for (dx = -1; dx <= 1; dx++)
				e &= grown_at(y + dy, x + dx);
		e &= grown_at(y - 2, x);
		e &= grown_at(y + 2, x);
		return e;
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// Register write; an unmapped index leaves everything alone
	function automatic void apply_write(input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] data);
		case (addr[2 +: REG_IDX_W])
			REG_OBJECT_IS_BLACK: mode_black = data[0];
			REG_IMAGE_WIDTH:     width_val  = data[SIZE_W-1:0];
			REG_IMAGE_HEIGHT:    height_val = data[SIZE_W-1:0];
			default:             return;
		endcase
		restart_frame();
	endfunction

	// One accepted beat: store the pixel, then release a result once it no longer lags
	function automatic void take_beat(input logic cmd, input logic [PIX_W-1:0] pix);
		int in_idx, out_idx, lag;
		bit done;
		closed_px_t r;
		w_eff = clip(int'(width_val), MIN_SIZE, MAX_WIDTH);
		h_eff = clip(int'(height_val), MIN_SIZE, MAX_HEIGHT);
		lag = 3 * w_eff + 1;
		done = in_row >= h_eff;
		in_idx = done ? w_eff * h_eff : in_row * w_eff + in_col;
		out_idx = out_row * w_eff + out_col;
		if (cmd == CMD_PIXEL && !done) begin
			row_ring[in_row % ROW_SLOTS][in_col % w_eff] =
				mode_black ? (pix == '0) : (pix == PIX_MAX);
			in_col++;
			if (in_col >= w_eff) begin
				in_col = 0;
				in_row++;
			end
			in_idx++;
			done = in_row >= h_eff;
		end
		if (out_idx >= in_idx)
			return;
		if (!done && in_idx < out_idx + lag + 1)
			return;
		r.pix  = (closed_at(out_row, out_col) ^ mode_black) ? PIX_MAX : '0;
		r.last = (out_row == h_eff - 1) && (out_col == w_eff - 1);
		closed_q.push_back(r);
		out_col++;
		if (out_col >= w_eff) begin
			out_col = 0;
			out_row++;
			if (out_row >= h_eff)
				restart_frame();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (row_ring[i, j])
				row_ring[i][j] = 1'b0;
			mode_black = 1'b0;
			width_val  = WIDTH_RST;
			height_val = HEIGHT_RST;
			restart_frame();
			closed_q.delete();
			mismatches = 0;
			compared   = 0;
			pending   <= 0;
		end else begin
			// Result beat: compare against the oldest prediction
			if (pop && !empty) begin
				compared++;
				if (closed_q.size() == 0) begin
					$error("unexpected result: pixel_out %0d frame_end %0d",
						pixel_out, frame_end);
					mismatches++;
				end else begin
					want = closed_q.pop_front();
					if (pixel_out !== want.pix) begin
						$error("pixel_out: expected %0d, got %0d", want.pix, pixel_out);
						mismatches++;
					end
					if (frame_end !== want.last) begin
						$error("frame_end: expected %0d, got %0d", want.last, frame_end);
						mismatches++;
					end
				end
			end
			if (psel && penable && pwrite && pready)
				apply_write(paddr, pwdata);
			if (push && !full)
				take_beat(command, pixel_in);
			pending <= closed_q.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the closing testbench: clock, reset, pixel and flush stimulus, register
// writes and the verdict. Instantiates binary_morphological_closing and
// closing_checker; uses bmc_pkg for widths and register indexes.
`timescale 1ns / 1ps

module testbench;
	import bmc_pkg::*;

	localparam logic                 CMD_FLUSH     = 1'b1;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED    = 2'd3;
	localparam int                   STALL_LIMIT   = 4000;
	localparam int                   SETTLE_CYCLES = 8;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              push     = 1'b0;
	logic              command  = 1'b0;
	logic [PIX_W-1:0]  pixel_in = '0;
	logic              pop      = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [APB_AW-1:0] paddr    = '0;
	logic [APB_DW-1:0] pwdata   = '0;
	logic              full, empty, frame_end, pready;
	logic [PIX_W-1:0]  pixel_out;
	logic [APB_DW-1:0] prdata;

	int mismatches, pending, compared;
	int send_idle = 0;
	int recv_idle = 0;
	int cur_w, cur_h;
	int pixel_beats = 0;
	int flush_beats = 0;
	int frames = 0;
	int settings = 0;
	int stall_cycles = 0;

	binary_morphological_closing dut (.*);

	closing_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.pixel_in(pixel_in), .empty(empty), .pop(pop), .pixel_out(pixel_out),
		.frame_end(frame_end), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .pending(pending), .compared(compared)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: random pop stalls
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog: too long without an accepted beat, pop or register access ends the run
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int fit_size(input int v, input int hi);
		return (v < MIN_SIZE) ? MIN_SIZE : (v > hi) ? hi : v;
	endfunction

	// Mostly 255 and 0 so that closing has something to do, some grey levels
	function automatic logic [PIX_W-1:0] rand_pixel(input int white_pct);
		int r;
		r = $urandom_range(99);
		if (r < white_pct)
			return PIX_MAX;
		if (r < 90)
			return '0;
		return PIX_W'($urandom_range(255));
	endfunction

	// One input beat; push stays high into the next beat unless the sender idles
	task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] pix);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		command  <= cmd;
		pixel_in <= pix;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (cmd == CMD_PIXEL)
			pixel_beats++;
		else
			flush_beats++;
	endtask

	// Stop sending and wait for every predicted result to be popped
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Full frame then the lagging results drained. With cut set, pause at that pixel
	// until drained, then either poke the unmapped register and go on, or abandon.
	task automatic run_frame(input int w, input int h, input bit noisy, input int cut,
			input bit abandon);
		int i, npix, lagging, white_pct;
		npix = w * h;
		lagging = (3 * w + 1 < npix - 1) ? 3 * w + 1 : npix - 1;
		white_pct = $urandom_range(10, 80);
		for (i = 0; i < npix; i++) begin
			if (cut != 0 && i == cut) begin
				settle();
				if (abandon)
					return;
				cfg_write(REG_UNUSED, $urandom);
			end
			// a flush mid-frame releases nothing
			if (noisy && $urandom_range(24) == 0)
				send_beat(CMD_FLUSH, PIX_W'($urandom_range(255)));
			send_beat(CMD_PIXEL, rand_pixel(white_pct));
		end
		// a pixel while outputs still lag is dropped and drains like a flush
		for (i = 0; i < lagging; i++) begin
			if (noisy && $urandom_range(9) == 0)
				send_beat(CMD_PIXEL, rand_pixel(white_pct));
			else
				send_beat(CMD_FLUSH, PIX_W'($urandom_range(255)));
		end
		if (noisy && $urandom_range(3) == 0)
			send_beat(CMD_FLUSH, PIX_W'($urandom_range(255)));
		frames++;
	endtask

	task automatic run_setting(input logic blk, input int wv, input int hv, input int nframes);
		int f;
		settle();
		cfg_write(REG_OBJECT_IS_BLACK, APB_DW'(blk));
		cfg_write(REG_IMAGE_WIDTH, APB_DW'(wv));
		cfg_write(REG_IMAGE_HEIGHT, APB_DW'(hv));
		cur_w = fit_size(wv & 32'h7FF, MAX_WIDTH);
		cur_h = fit_size(hv & 32'h7FF, MAX_HEIGHT);
		settings++;
		for (f = 0; f < nframes; f++)
			run_frame(cur_w, cur_h, 1'b1, 0, 1'b0);
	endtask

	// Small random frames, now and then an undersized register value
	task automatic random_settings(input int quota);
		int start, wv, hv;
		start = pixel_beats + flush_beats;
		while (pixel_beats + flush_beats - start < quota) begin
			wv = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
			hv = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
			run_setting(1'($urandom_range(1)), wv, hv, $urandom_range(1, 2));
		end
	endtask

	initial begin
		logic [PIX_W-1:0] corner_px [9];
		int i;
		corner_px = '{8'd255, 8'd0, 8'd254, 8'd1, 8'd128, 8'd127, 8'd255, 8'd0, 8'd255};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles lightly, receiver heavily
		send_idle = 34;
		recv_idle = 78;

		// Directed: smallest white-mode frame with grey levels, flushes and dropped pixels
		run_setting(1'b0, 3, 3, 0);
		send_beat(CMD_FLUSH, 8'd255);
		for (i = 0; i < 9; i++)
			send_beat(CMD_PIXEL, corner_px[i]);
		send_beat(CMD_FLUSH, 8'd0);
		send_beat(CMD_PIXEL, 8'd255);
		send_beat(CMD_FLUSH, 8'd0);
		send_beat(CMD_PIXEL, 8'd0);
		for (i = 0; i < 4; i++)
			send_beat(CMD_FLUSH, 8'd0);
		send_beat(CMD_FLUSH, 8'd0);
		frames++;

		run_setting(1'b1, 5, 4, 2);
		run_setting(1'b0, 0, 1, 2);
		// Oversized width: start of a frame only, then abandoned
		run_setting(1'b0, 2047, 3, 0);
		run_frame(cur_w, cur_h, 1'b1, 30, 1'b1);
		random_settings(50);

		// Heavy sender idling, light pop stalls
		send_idle = 78;
		recv_idle = 34;
		run_setting(1'b1, 3, 1024, 0);
		run_frame(cur_w, cur_h, 1'b1, 50, 1'b1);
		run_setting(1'b0, 6, 5, 0);
		run_frame(cur_w, cur_h, 1'b1, 13, 1'b0);
		run_setting(1'b1, 4, 8, 0);
		run_frame(cur_w, cur_h, 1'b1, 20, 1'b1);
		random_settings(50);

		// Full rate both ways
		send_idle = 0;
		recv_idle = 0;
		run_setting(1'b1, 1024, 3, 0);
		run_frame(cur_w, cur_h, 1'b1, 30, 1'b1);
		run_setting(1'b0, 3, 2047, 0);
		run_frame(cur_w, cur_h, 1'b1, 50, 1'b1);
		random_settings(50);

		settle();
		$display("Covered %0d frames over %0d register settings in both object modes,",
			frames, settings);
		$display("%0d pixel beats, %0d flush beats, %0d results compared.",
			pixel_beats, flush_beats, compared);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bmc_pkg.sv
rtl/bmc_front.sv
rtl/bmc_fifo.sv
rtl/bmc_back.sv
rtl/binary_morphological_closing.sv
bench/closing_checker.sv
bench/testbench.sv
